// ----- hdl/wds_pkg.sv -----
// -----------------------------------------------------------------------------
// Window difference statistics package
// Shared widths, register indexes, mode codes and the window flag type.
// -----------------------------------------------------------------------------
package wds_pkg;

   localparam int MAX_WINDOW_PIXELS_DEF = 65536;

   localparam int PIXEL_W     = 8;
   localparam int MEAN_W      = 17;
   localparam int SPREAD_W    = 24;
   localparam int COUNT_OUT_W = 17;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 2;

   // quotient bits of the shared divider; both statistics stay below 2**24
   localparam int QUO_W = 24;

   localparam int MEAN_MAX_Q8   = 65280;
   localparam int SPREAD_MAX_Q8 = 16646400;

   typedef enum logic [MODE_W-1:0] {
      MODE_MEAN_SQUARE = 2'd0,
      MODE_VARIANCE    = 2'd1,
      MODE_MEAN_ABS    = 2'd2
   } stat_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STAT_MODE   = 1'b0,
      CSR_MASK_ENABLE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic          saturated;
      stat_mode_type mode;
   } win_flags_type;

endpackage

// ----- hdl/wds_req_if.sv -----
// -----------------------------------------------------------------------------
// Pixel pair channel
// Valid/ready channel carrying one pixel pair with its mask and last flags.
// -----------------------------------------------------------------------------
interface wds_req_if;
   logic                          valid;
   logic                          ready;
   logic [wds_pkg::PIXEL_W-1:0]   pixel_a;
   logic [wds_pkg::PIXEL_W-1:0]   pixel_b;
   logic                          mask_on;
   logic                          last;

   modport source (output valid, output pixel_a, output pixel_b, output mask_on,
                   output last, input ready);
   modport sink (input valid, input pixel_a, input pixel_b, input mask_on,
                 input last, output ready);
endinterface

// ----- hdl/wds_rsp_if.sv -----
// -----------------------------------------------------------------------------
// Window result channel
// Valid/ready channel carrying the statistics of one finished window.
// -----------------------------------------------------------------------------
interface wds_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [wds_pkg::MEAN_W-1:0]   mean_q8;
   logic [wds_pkg::SPREAD_W-1:0]        spread_q8;
   logic [wds_pkg::COUNT_OUT_W-1:0]     pixel_count;
   logic                                empty_window;
   logic                                count_overflow;

   modport source (output valid, output mean_q8, output spread_q8, output pixel_count,
                   output empty_window, output count_overflow, input ready);
   modport sink (input valid, input mean_q8, input spread_q8, input pixel_count,
                 input empty_window, input count_overflow, output ready);
endinterface

// ----- hdl/wds_front.sv -----
// -----------------------------------------------------------------------------
// Window difference statistics front end
// Holds the registers, takes one pixel pair per cycle unless the queue is
// full, accumulates the window sums and pushes a snapshot on the last pixel.
// -----------------------------------------------------------------------------
module wds_front #(
   parameter int  MAX_WINDOW_PIXELS = wds_pkg::MAX_WINDOW_PIXELS_DEF,
   localparam int CNT_W = $clog2(MAX_WINDOW_PIXELS + 1),
   localparam int SUM_W = CNT_W + 8,
   localparam int SQ_W  = CNT_W + 16
) (
   input  logic                             clock,
   input  logic                             reset,
   wds_req_if.sink                          req_port,
   input  logic                             csr_write_enable,
   input  logic [wds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wds_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             queue_full,
   output logic                             push,
   output logic signed [SUM_W:0]            push_diff,
   output logic [SQ_W-1:0]                  push_second,
   output logic [CNT_W-1:0]                 push_count,
   output wds_pkg::win_flags_type           push_flags
);

   wds_pkg::stat_mode_type stat_mode_ff, stat_mode_in;
   logic                   mask_enable_ff, mask_enable_in;

   logic signed [SUM_W:0]  diff_total_ff, diff_total_in, diff_upd;
   logic [SQ_W-1:0]        second_total_ff, second_total_in, second_upd;
   logic [CNT_W-1:0]       counted_ff, counted_in, counted_upd;
   logic                   saturated_ff, saturated_in, saturated_upd;

   logic                   accept;
   logic                   take;
   logic                   at_limit;
   logic signed [8:0]      pix_diff;
   logic signed [8:0]      pix_diff_neg;
   logic [7:0]             pix_mag;
   logic [15:0]            pix_sq;
   logic [SQ_W-1:0]        second_inc;

   always_comb begin
      stat_mode_in   = stat_mode_ff;
      mask_enable_in = mask_enable_ff;
      if (csr_write_enable) begin
         unique case (wds_pkg::csr_index_type'(csr_index))
            wds_pkg::CSR_STAT_MODE: begin
               stat_mode_in = wds_pkg::stat_mode_type'(csr_write_data[wds_pkg::MODE_W-1:0]);
            end
            wds_pkg::CSR_MASK_ENABLE: begin
               mask_enable_in = csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_port.ready = !queue_full;
   assign accept         = req_port.valid && req_port.ready;
   assign take           = !(mask_enable_ff && !req_port.mask_on);
   assign at_limit       = (counted_ff == CNT_W'(MAX_WINDOW_PIXELS));

   assign pix_diff     = signed'({1'b0, req_port.pixel_b}) - signed'({1'b0, req_port.pixel_a});
   assign pix_diff_neg = -pix_diff;
   assign pix_mag      = pix_diff[8] ? pix_diff_neg[7:0] : pix_diff[7:0];
   assign pix_sq       = pix_mag * pix_mag;
   assign second_inc   = (stat_mode_ff == wds_pkg::MODE_MEAN_ABS) ? SQ_W'(pix_mag)
                                                                  : SQ_W'(pix_sq);

   // window totals including the pixel now on the channel
   always_comb begin
      diff_upd      = diff_total_ff;
      second_upd    = second_total_ff;
      counted_upd   = counted_ff;
      saturated_upd = saturated_ff;
      if (take) begin
         if (at_limit) begin
            saturated_upd = 1'b1;
         end else begin
            diff_upd    = diff_total_ff + (SUM_W + 1)'(pix_diff);
            second_upd  = second_total_ff + second_inc;
            counted_upd = counted_ff + 1'b1;
         end
      end
   end

   always_comb begin
      diff_total_in   = diff_total_ff;
      second_total_in = second_total_ff;
      counted_in      = counted_ff;
      saturated_in    = saturated_ff;
      if (accept) begin
         if (req_port.last) begin
            diff_total_in   = '0;
            second_total_in = '0;
            counted_in      = '0;
            saturated_in    = 1'b0;
         end else begin
            diff_total_in   = diff_upd;
            second_total_in = second_upd;
            counted_in      = counted_upd;
            saturated_in    = saturated_upd;
         end
      end
   end

   assign push                 = accept && req_port.last;
   assign push_diff            = diff_upd;
   assign push_second          = second_upd;
   assign push_count           = counted_upd;
   assign push_flags.saturated = saturated_upd;
   assign push_flags.mode      = stat_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_mode_ff    <= wds_pkg::MODE_MEAN_SQUARE;
         mask_enable_ff  <= 1'b0;
         diff_total_ff   <= '0;
         second_total_ff <= '0;
         counted_ff      <= '0;
         saturated_ff    <= 1'b0;
      end else begin
         stat_mode_ff    <= stat_mode_in;
         mask_enable_ff  <= mask_enable_in;
         diff_total_ff   <= diff_total_in;
         second_total_ff <= second_total_in;
         counted_ff      <= counted_in;
         saturated_ff    <= saturated_in;
      end
   end

endmodule

// ----- hdl/wds_queue.sv -----
// -----------------------------------------------------------------------------
// Window snapshot queue
// Two-entry queue between the front end and the back end.
// -----------------------------------------------------------------------------
module wds_queue #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign full     = (fill_ff == 2'(DEPTH));
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = 2'(fill_ff + 2'(push) - 2'(pop));
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue overrun");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue underrun");
`endif

endmodule

// ----- hdl/wds_divider.sv -----
// -----------------------------------------------------------------------------
// Window difference statistics divider
// Restoring divider, one quotient bit per cycle; the caller guarantees that
// the quotient fits QUO_W bits.
// -----------------------------------------------------------------------------
module wds_divider #(
   parameter int  DIVISOR_W  = 34,
   parameter int  QUO_W      = wds_pkg::QUO_W,
   localparam int DIVIDEND_W = DIVISOR_W + QUO_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [QUO_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(QUO_W);

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   trial_sub;
   logic                 fits;
   logic                 last_step;

   assign trial     = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign fits      = (trial >= {1'b0, divisor_ff});
   assign last_step = (step_ff == STEP_W'(QUO_W - 1));

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = dividend[DIVIDEND_W-1:QUO_W];
         quo_in     = dividend[QUO_W-1:0];
         divisor_in = divisor;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");
   assert property (@(posedge clock) disable iff (reset) start |-> (divisor != '0))
      else $error("divider started with zero divisor");
`endif

endmodule

// ----- hdl/wds_back.sv -----
// -----------------------------------------------------------------------------
// Window difference statistics back end
// Takes window snapshots from the queue, forms the products, runs the mean
// and spread divisions and holds the result for transfer.
// -----------------------------------------------------------------------------
module wds_back #(
   parameter int  MAX_WINDOW_PIXELS = wds_pkg::MAX_WINDOW_PIXELS_DEF,
   localparam int CNT_W = $clog2(MAX_WINDOW_PIXELS + 1),
   localparam int SUM_W = CNT_W + 8,
   localparam int SQ_W  = CNT_W + 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   output logic                    pop,
   input  logic signed [SUM_W:0]   pop_diff,
   input  logic [SQ_W-1:0]         pop_second,
   input  logic [CNT_W-1:0]        pop_count,
   input  wds_pkg::win_flags_type  pop_flags,
   wds_rsp_if.source               rsp_port
);

   localparam int PROD_W     = SQ_W + CNT_W;
   localparam int DIV_W      = 2 * CNT_W;
   localparam int DIVIDEND_W = DIV_W + wds_pkg::QUO_W;
   localparam int MEAN_W     = wds_pkg::MEAN_W;
   localparam int SPREAD_W   = wds_pkg::SPREAD_W;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL    = 6'b000010,
      ST_MEAN   = 6'b000100,
      ST_LOAD   = 6'b001000,
      ST_SPREAD = 6'b010000,
      ST_OUT    = 6'b100000
   } back_state_type;

   back_state_type         state_ff, state_in;

   logic [SUM_W-1:0]       dmag_ff, dmag_in;
   logic                   neg_ff, neg_in;
   logic [SQ_W-1:0]        second_ff, second_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   wds_pkg::win_flags_type flags_ff, flags_in;
   logic [PROD_W-1:0]      sn_ff, sn_in;
   logic [PROD_W-1:0]      dsq_ff, dsq_in;
   logic [DIV_W-1:0]       nsq_ff, nsq_in;
   logic [MEAN_W-1:0]      mean_ff, mean_in;
   logic [SPREAD_W-1:0]    spread_ff, spread_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]      rsp_mean_ff, rsp_mean_in;
   logic [SPREAD_W-1:0]    rsp_spread_ff, rsp_spread_in;
   logic [wds_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   div_start;
   logic [DIVIDEND_W-1:0]  div_dividend;
   logic [DIV_W-1:0]       div_divisor;
   logic                   div_done;
   logic [wds_pkg::QUO_W-1:0] div_quotient;

   logic [SUM_W:0]         pop_diff_neg;
   logic [MEAN_W-1:0]      mean_mag;
   logic [PROD_W-1:0]      var_num;
   logic                   var_clamp;
   logic                   is_variance;

   assign pop_diff_neg = -pop_diff;
   assign mean_mag     = div_quotient[MEAN_W-1:0];
   assign var_num      = sn_ff - dsq_ff;
   assign var_clamp    = (sn_ff <= dsq_ff);
   assign is_variance  = (flags_ff.mode == wds_pkg::MODE_VARIANCE);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIVIDEND_W'({dmag_ff, 8'b0});
      div_divisor  = DIV_W'(count_ff);
      if (state_ff == ST_MUL) begin
         div_start = 1'b1;
      end else if (state_ff == ST_LOAD) begin
         if (is_variance) begin
            div_start    = !var_clamp;
            div_dividend = DIVIDEND_W'({var_num, 8'b0});
            div_divisor  = nsq_ff;
         end else begin
            div_start    = 1'b1;
            div_dividend = DIVIDEND_W'({second_ff, 8'b0});
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      pop           = 1'b0;
      dmag_in       = dmag_ff;
      neg_in        = neg_ff;
      second_in     = second_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      sn_in         = sn_ff;
      dsq_in        = dsq_ff;
      nsq_in        = nsq_ff;
      mean_in       = mean_ff;
      spread_in     = spread_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_mean_in   = rsp_mean_ff;
      rsp_spread_in = rsp_spread_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               neg_in    = pop_diff[SUM_W];
               dmag_in   = pop_diff[SUM_W] ? pop_diff_neg[SUM_W-1:0] : pop_diff[SUM_W-1:0];
               second_in = pop_second;
               count_in  = pop_count;
               flags_in  = pop_flags;
               if (pop_count == '0) begin
                  mean_in   = '0;
                  spread_in = '0;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            sn_in    = second_ff * count_ff;
            dsq_in   = dmag_ff * dmag_ff;
            nsq_in   = count_ff * count_ff;
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            if (div_done) begin
               mean_in  = neg_ff ? (~mean_mag + 1'b1) : mean_mag;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (is_variance && var_clamp) begin
               spread_in = '0;
               state_in  = ST_OUT;
            end else begin
               state_in = ST_SPREAD;
            end
         end
         ST_SPREAD: begin
            if (div_done) begin
               spread_in = div_quotient[SPREAD_W-1:0];
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = mean_ff;
               rsp_spread_in = spread_ff;
               rsp_count_in  = wds_pkg::COUNT_OUT_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               rsp_ovf_in    = flags_ff.saturated;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   wds_divider #(
      .DIVISOR_W (DIV_W),
      .QUO_W     (wds_pkg::QUO_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.mean_q8        = $signed(rsp_mean_ff);
   assign rsp_port.spread_q8      = rsp_spread_ff;
   assign rsp_port.pixel_count    = rsp_count_ff;
   assign rsp_port.empty_window   = rsp_empty_ff;
   assign rsp_port.count_overflow = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      dmag_ff       <= dmag_in;
      neg_ff        <= neg_in;
      second_ff     <= second_in;
      count_ff      <= count_in;
      flags_ff      <= flags_in;
      sn_ff         <= sn_in;
      dsq_ff        <= dsq_in;
      nsq_ff        <= nsq_in;
      mean_ff       <= mean_in;
      spread_ff     <= spread_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_spread_ff <= rsp_spread_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MEAN && div_done) |->
         (div_quotient <= wds_pkg::QUO_W'(wds_pkg::MEAN_MAX_Q8)))
      else $error("mean quotient out of range");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPREAD && div_done) |->
         (div_quotient <= wds_pkg::QUO_W'(wds_pkg::SPREAD_MAX_Q8)))
      else $error("spread quotient out of range");
`endif

endmodule

// ----- hdl/window_difference_statistics.sv -----
// -----------------------------------------------------------------------------
// Window difference statistics
// Accumulates pixel pair differences over a window and reports the Q8 mean
// difference and a mode-selected spread (mean square, variance, mean abs).
// -----------------------------------------------------------------------------
//   channel   dir   handshake           payload
//   req_port  in    valid/ready         pixel_a, pixel_b, mask_on, last
//   rsp_port  out   valid/ready         mean_q8, spread_q8, pixel_count,
//                                       empty_window, count_overflow
//   csr_*     in    csr_write_enable    csr_index, csr_write_data
//
// Front end takes one pixel pair per cycle while the queue is not full.
// Back end runs the shared 24-step restoring divider for the mean, then
// the spread (skipped for an empty window; no spread for a clamped variance),
// one window at a time. Two finished windows queue between the two parts;
// req_port.ready drops while the queue is full.
// Synchronous reset clears control and front-end state; no clearing pass.
// -----------------------------------------------------------------------------
module window_difference_statistics #(
   parameter int MAX_WINDOW_PIXELS = wds_pkg::MAX_WINDOW_PIXELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   wds_req_if.sink                          req_port,
   wds_rsp_if.source                        rsp_port,
   input  logic                             csr_write_enable,
   input  logic [wds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wds_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int CNT_W   = $clog2(MAX_WINDOW_PIXELS + 1);
   localparam int SUM_W   = CNT_W + 8;
   localparam int SQ_W    = CNT_W + 16;
   localparam int ENTRY_W = (SUM_W + 1) + SQ_W + CNT_W + $bits(wds_pkg::win_flags_type);

   logic                   push;
   logic signed [SUM_W:0]  push_diff;
   logic [SQ_W-1:0]        push_second;
   logic [CNT_W-1:0]       push_count;
   wds_pkg::win_flags_type push_flags;

   logic                   pop;
   logic signed [SUM_W:0]  pop_diff;
   logic [SQ_W-1:0]        pop_second;
   logic [CNT_W-1:0]       pop_count;
   wds_pkg::win_flags_type pop_flags;

   logic [ENTRY_W-1:0]     push_data;
   logic [ENTRY_W-1:0]     pop_data;
   logic                   queue_full;
   logic                   queue_empty;

   wds_front #(
      .MAX_WINDOW_PIXELS (MAX_WINDOW_PIXELS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_port),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_diff        (push_diff),
      .push_second      (push_second),
      .push_count       (push_count),
      .push_flags       (push_flags)
   );

   assign push_data = {push_diff, push_second, push_count, push_flags};
   assign {pop_diff, pop_second, pop_count, pop_flags} = pop_data;

   wds_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   wds_back #(
      .MAX_WINDOW_PIXELS (MAX_WINDOW_PIXELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop         (pop),
      .pop_diff    (pop_diff),
      .pop_second  (pop_second),
      .pop_count   (pop_count),
      .pop_flags   (pop_flags),
      .rsp_port    (rsp_port)
   );

endmodule
